>>> hw/rtl/mmms_pkg.sv
// ----------------------------------------------------------------------------
// mmms_pkg
// Shared types and constants for the mean, median and mode statistics unit.
// ----------------------------------------------------------------------------
package mmms_pkg;

   localparam int SAMPLE_W         = 10;
   localparam int COUNT_W          = 6;
   localparam int COUNT_MAX        = 63;
   localparam int QUOT_W           = 10;
   localparam int SET_SIZE_DEFAULT = 32;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_LAST,
      ST_EVAL,
      ST_DIV,
      ST_DONE
   } stats_state_type;

endpackage

>>> hw/rtl/mean_median_mode_stats_unit.sv
// ----------------------------------------------------------------------------
// mean_median_mode_stats_unit
// Collects a set of SET_SIZE samples and reports the truncated mean, the
// median and the mode of the set through one shared compare unit.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | word
//  req     | in        | req_valid / req_stall  | sample
//  rsp     | out       | rsp_valid / rsp_stall  | mean, median, mode, mode_count,
//          |           |                        | has_mode
//
//  Loading takes one sample per cycle while req_stall is low; the last sample
//  of a set starts the rank scan of each sample against the set on the single
//  compare unit, then a reciprocal multiplication for the mean and the posting step.
//  Reset is synchronous and active high; it empties the set and the output.
//  The result sits in an output register: the next set loads while it waits,
//  and rsp_stall only holds back a finished set that finds it still occupied.
// ----------------------------------------------------------------------------
module mean_median_mode_stats_unit
   import mmms_pkg::*;
#(
   parameter int SET_SIZE = SET_SIZE_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_sample,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SAMPLE_W-1:0] rsp_mean,
   output logic [SAMPLE_W-1:0] rsp_median,
   output logic [SAMPLE_W-1:0] rsp_mode,
   output logic [COUNT_W-1:0]  rsp_mode_count,
   output logic                rsp_has_mode
);

   localparam int ADDR_W = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
   localparam int CNT_W  = $clog2(SET_SIZE + 1);
   localparam int SUM_W  = SAMPLE_W + CNT_W;
   localparam int DIV_SH = SUM_W + $clog2(SET_SIZE);
   localparam int RCP_W  = SUM_W + 1;
   localparam int PROD_W = SUM_W + RCP_W;

   localparam longint RCP_VAL = ((longint'(1) << DIV_SH) + longint'(SET_SIZE) - 1) /
                                longint'(SET_SIZE);

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SET_SIZE - 1);
   localparam logic [CNT_W-1:0]  LO_POS    = CNT_W'((SET_SIZE - 1) / 2);
   localparam logic [CNT_W-1:0]  HI_POS    = CNT_W'(SET_SIZE / 2);
   localparam logic [RCP_W-1:0]  RECIP     = RCP_W'(RCP_VAL);

   logic [SAMPLE_W-1:0] mem [SET_SIZE];
   logic [SAMPLE_W-1:0] rd_a_ff;
   logic [SAMPLE_W-1:0] rd_b_ff;
   logic                wr_en;

   stats_state_type     state_ff,     state_in;
   logic [ADDR_W-1:0]   load_cnt_ff,  load_cnt_in;
   logic [SUM_W-1:0]    sum_ff,       sum_in;
   logic [ADDR_W-1:0]   i_ff,         i_in;
   logic [ADDR_W-1:0]   j_ff,         j_in;
   logic                cmp_vld_ff,   cmp_vld_in;
   logic [CNT_W-1:0]    lt_ff,        lt_in;
   logic [CNT_W-1:0]    eq_ff,        eq_in;
   logic [CNT_W-1:0]    best_cnt_ff,  best_cnt_in;
   logic [SAMPLE_W-1:0] best_val_ff,  best_val_in;
   logic [SAMPLE_W-1:0] lo_ff,        lo_in;
   logic [SAMPLE_W-1:0] hi_ff,        hi_in;
   logic [SUM_W-1:0]    rem_ff,       rem_in;
   logic [QUOT_W-1:0]   quot_ff,      quot_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] mean_ff,      mean_in;
   logic [SAMPLE_W-1:0] median_ff,    median_in;
   logic [SAMPLE_W-1:0] mode_ff,      mode_in;
   logic [COUNT_W-1:0]  mcount_ff,    mcount_in;
   logic                has_mode_ff,  has_mode_in;

   logic [CNT_W-1:0]    le_cnt;
   logic [PROD_W-1:0]   prod;
   logic [31:0]         best_ext;
   logic [SAMPLE_W:0]   mid_sum;
   logic                out_free;

   assign req_stall      = (state_ff != ST_LOAD);
   assign wr_en          = req_valid && (state_ff == ST_LOAD);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mean       = mean_ff;
   assign rsp_median     = median_ff;
   assign rsp_mode       = mode_ff;
   assign rsp_mode_count = mcount_ff;
   assign rsp_has_mode   = has_mode_ff;

   assign le_cnt   = lt_ff + eq_ff;
   assign prod     = PROD_W'(rem_ff) * PROD_W'(RECIP);
   assign best_ext = 32'(best_cnt_ff);
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[load_cnt_ff] <= req_sample;
      end
      rd_a_ff <= mem[i_ff];
      rd_b_ff <= mem[j_ff];
   end

   always_comb begin
      state_in     = state_ff;
      load_cnt_in  = load_cnt_ff;
      sum_in       = sum_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      cmp_vld_in   = (state_ff == ST_SCAN);
      lt_in        = lt_ff;
      eq_in        = eq_ff;
      best_cnt_in  = best_cnt_ff;
      best_val_in  = best_val_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mean_in      = mean_ff;
      median_in    = median_ff;
      mode_in      = mode_ff;
      mcount_in    = mcount_ff;
      has_mode_in  = has_mode_ff;

      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               sum_in = sum_ff + SUM_W'(req_sample);
               if (load_cnt_ff == LAST_ADDR) begin
                  load_cnt_in = '0;
                  i_in        = '0;
                  j_in        = '0;
                  lt_in       = '0;
                  eq_in       = '0;
                  best_cnt_in = '0;
                  best_val_in = '0;
                  state_in    = ST_SCAN;
               end else begin
                  load_cnt_in = load_cnt_ff + 1'b1;
               end
            end
         end
         ST_SCAN, ST_LAST: begin
            if (cmp_vld_ff) begin
               if (rd_b_ff < rd_a_ff) begin
                  lt_in = lt_ff + 1'b1;
               end
               if (rd_b_ff == rd_a_ff) begin
                  eq_in = eq_ff + 1'b1;
               end
            end
            if (state_ff == ST_LAST) begin
               state_in = ST_EVAL;
            end else if (j_ff == LAST_ADDR) begin
               state_in = ST_LAST;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_EVAL: begin
            if ((eq_ff > best_cnt_ff) ||
                ((eq_ff == best_cnt_ff) && (rd_a_ff < best_val_ff))) begin
               best_cnt_in = eq_ff;
               best_val_in = rd_a_ff;
            end
            if ((lt_ff <= LO_POS) && (LO_POS < le_cnt)) begin
               lo_in = rd_a_ff;
            end
            if ((lt_ff <= HI_POS) && (HI_POS < le_cnt)) begin
               hi_in = rd_a_ff;
            end
            lt_in = '0;
            eq_in = '0;
            j_in  = '0;
            if (i_ff == LAST_ADDR) begin
               rem_in   = sum_ff;
               sum_in   = '0;
               quot_in  = '0;
               state_in = ST_DIV;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_DIV: begin
            quot_in  = prod[DIV_SH +: QUOT_W];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               mean_in      = quot_ff;
               median_in    = mid_sum[SAMPLE_W:1];
               if (best_cnt_ff > CNT_W'(1)) begin
                  mode_in     = best_val_ff;
                  mcount_in   = (best_ext > 32'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                            : best_ext[COUNT_W-1:0];
                  has_mode_in = 1'b1;
               end else begin
                  mode_in     = '0;
                  mcount_in   = COUNT_W'(1);
                  has_mode_in = 1'b0;
               end
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         load_cnt_ff  <= '0;
         sum_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         sum_ff       <= sum_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      lt_ff       <= lt_in;
      eq_ff       <= eq_in;
      best_cnt_ff <= best_cnt_in;
      best_val_ff <= best_val_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      mean_ff     <= mean_in;
      median_ff   <= median_in;
      mode_ff     <= mode_in;
      mcount_ff   <= mcount_in;
      has_mode_ff <= has_mode_in;
   end

`ifndef SYNTHESIS
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result word raised outside the posting step");

   a_self_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |-> (eq_ff != '0))
      else $error("rank scan missed the element itself");

   a_rank_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |-> (32'(lt_ff) + 32'(eq_ff) <= SET_SIZE))
      else $error("rank counts exceed the set size");

   a_pivot_hold: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && $past(state_ff == ST_SCAN)) |-> $stable(i_ff))
      else $error("pivot moved during a scan");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (load_cnt_ff == '0))
      else $error("load count not cleared while the set is processed");
`endif

endmodule
